FILE: sv/nearest_palette_color_search_core_defines.svh
// Assertion macros shared by the checker of the nearest palette color search core.
// No dependencies; included by the checker file only.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_CORE_DEFINES_SVH

// Implication to the next cycle, switched off while reset is high.
`define NPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npcs checker: next-cycle property failed");

// Implication to the next cycle that also holds across reset.
`define NPCS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("npcs checker: reset property failed");

`endif

FILE: sv/npcs_pkg.sv
// Package of the nearest palette color search core: widths, codes and shared types.
// No dependencies; imported by every module of the core.
package npcs_pkg;

   // Default palette depth and fixed field widths.
   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int COMP_W              = 8;
   localparam int IDX_W               = 8;
   localparam int COLOR_W             = 15;
   localparam int CHAN_W              = 5;
   localparam int SQ_W                = 2 * COMP_W;
   localparam int DIST_W              = SQ_W + 2;
   localparam int REQ_DATA_W          = 48;
   localparam int RSP_DATA_W          = 8;

   // A 5-bit channel expands to 8 bits as value*8+4.
   localparam logic [2:0] EXPAND_BIAS = 3'd4;

   // Operation codes carried in tuser.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // One palette color, 24 bits.
   typedef struct packed {
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] red;
   } color_type;

   // Control that travels with each palette read of a scan.
   typedef struct packed {
      logic             vld;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

endpackage

FILE: sv/npcs_palette_ram.sv
// Palette memory of the nearest palette color search core, one write and one read port.
// Depends on npcs_pkg; valid bits make unwritten entries read as zero after reset.
module npcs_palette_ram #(
   parameter int ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF,
   parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  npcs_pkg::color_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output npcs_pkg::color_type rd_data
);
   import npcs_pkg::*;

   color_type          mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   color_type          rd_data_ff;
   logic               rd_valid_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Per-entry valid bits, cleared at once by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // An entry never written since reset reads as black.
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: sv/npcs_dist_unit.sv
// Distance and best-match tracker of the nearest palette color search core.
// Depends on npcs_pkg; consumes one palette entry per cycle from npcs_palette_ram.
module npcs_dist_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  npcs_pkg::scan_ctl_type       ctl,
   input  npcs_pkg::color_type          qry,
   input  npcs_pkg::color_type          ent,
   output logic                         done,
   output logic [npcs_pkg::IDX_W-1:0]   best_idx
);
   import npcs_pkg::*;

   scan_ctl_type      ctl_a_ff;
   scan_ctl_type      ctl_b_ff;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SQ_W-1:0]   sq_r_in, sq_g_in, sq_b_in;
   logic [DIST_W-1:0] dist_sum;
   logic [DIST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              done_ff;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] d;
      logic [SQ_W-1:0]   dw;
      d  = (a > b) ? (a - b) : (b - a);
      dw = {{(SQ_W-COMP_W){1'b0}}, d};
      return dw * dw;
   endfunction

   // Squared channel differences for the entry that left the memory this cycle.
   always_comb begin
      sq_r_in = sq_diff(qry.red,   ent.red);
      sq_g_in = sq_diff(qry.green, ent.green);
      sq_b_in = sq_diff(qry.blue,  ent.blue);
   end

   always_ff @(posedge clock) begin
      sq_r_ff <= sq_r_in;
      sq_g_ff <= sq_g_in;
      sq_b_ff <= sq_b_in;
   end

   // Control follows the data: one stage for the memory read, one for the squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         ctl_a_ff <= ctl;
         ctl_b_ff <= ctl_a_ff;
         done_ff  <= ctl_b_ff.vld && ctl_b_ff.last;
      end
   end

   // Sum of squares, then a strict compare so the lowest index wins a tie.
   assign dist_sum = {2'b00, sq_r_ff} + {2'b00, sq_g_ff} + {2'b00, sq_b_ff};

   always_ff @(posedge clock) begin
      if (ctl_b_ff.vld && (ctl_b_ff.first || (dist_sum < best_dist_ff))) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= ctl_b_ff.idx;
      end
   end

   assign done     = done_ff;
   assign best_idx = best_idx_ff;

endmodule

FILE: sv/nearest_palette_color_search_core.sv
// Top level of the nearest palette color search core: handshakes, scan sequencer, result word.
// Depends on npcs_pkg, npcs_palette_ram and npcs_dist_unit.
//
//   channel | ports                 | word
//   --------+-----------------------+----------------------------------------------
//   request | req_tvalid/tready     | tuser: operation; tdata: index, r, g, b, color
//   result  | rsp_tvalid/tready     | tdata: nearest index, one word per query
//
// A load word writes the palette memory directly.
// In a query, the scan reads one palette entry per cycle from the single memory
// read port, then three pipeline stages drain.
// Reset clears the valid bits of all entries at once, so no clearing pass is needed.
// A result waiting on rsp_tready holds the core before a new request is taken only
// if a further query finishes; loads and the next scan proceed meanwhile.
module nearest_palette_color_search_core #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bit 0: operation
   input  logic                                req_tuser,
   // 7:0 entry_index, 15:8 red, 23:16 green, 31:24 blue, 46:32 query_color, 47 zero
   input  logic [npcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // 7:0 nearest_index
   output logic [npcs_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import npcs_pkg::*;

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [AW-1:0]    LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
   localparam logic [IDX_W:0]   ENTRY_LIM = (IDX_W + 1)'(PALETTE_ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_PUT  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   color_type             qry_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_acc;
   logic [IDX_W-1:0]      f_index;
   logic [COLOR_W-1:0]    f_color;
   color_type             f_entry;
   logic                  wr_en;
   scan_ctl_type          ctl;
   color_type             ent;
   logic                  done;
   logic [IDX_W-1:0]      best_idx;

   // Request word fields.
   assign req_acc       = req_tvalid && req_tready;
   assign f_index       = req_tdata[7:0];
   assign f_entry.red   = req_tdata[15:8];
   assign f_entry.green = req_tdata[23:16];
   assign f_entry.blue  = req_tdata[31:24];
   assign f_color       = req_tdata[46:32];

   // Loads beyond the palette depth are dropped.
   assign wr_en = req_acc && (req_tuser == OP_LOAD) && ({1'b0, f_index} < ENTRY_LIM);

   // Scan control for the read issued this cycle.
   always_comb begin
      ctl       = '0;
      ctl.vld   = (state_ff == ST_SCAN);
      ctl.first = (cnt_ff == '0);
      ctl.last  = (cnt_ff == LAST_ADDR);
      ctl.idx   = IDX_W'(cnt_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == OP_QUERY)) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'(best_idx);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Query color expanded to 8 bits per channel when the query is taken.
   always_ff @(posedge clock) begin
      if (req_acc && (req_tuser == OP_QUERY)) begin
         qry_ff.red   <= {f_color[CHAN_W-1:0],          EXPAND_BIAS};
         qry_ff.green <= {f_color[2*CHAN_W-1:CHAN_W],   EXPAND_BIAS};
         qry_ff.blue  <= {f_color[3*CHAN_W-1:2*CHAN_W], EXPAND_BIAS};
      end
   end

   npcs_palette_ram #(
      .ENTRIES (PALETTE_ENTRIES),
      .AW      (AW)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (f_index[AW-1:0]),
      .wr_data (f_entry),
      .rd_addr (cnt_ff),
      .rd_data (ent)
   );

   npcs_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .qry      (qry_ff),
      .ent      (ent),
      .done     (done),
      .best_idx (best_idx)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/npcs_checker.sv
// Port-level checker of the nearest palette color search core, bound to the top level.
// Depends on nearest_palette_color_search_core_defines.svh for the assertion macros.
`include "nearest_palette_color_search_core_defines.svh"

module npcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result word stays on the bus unchanged.
   `NPCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A load never produces a result word.
   `NPCS_ASSERT_NEXT(a_load_silent, clock, reset, req_tvalid && req_tready && !req_tuser && !rsp_tvalid, !rsp_tvalid && req_tready)

   // A query occupies the core: no request is taken in the next cycle.
   `NPCS_ASSERT_NEXT(a_query_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready)

   // A query's result cannot appear in the cycle right after it is taken.
   `NPCS_ASSERT_NEXT(a_query_latency, clock, reset, req_tvalid && req_tready && req_tuser && !rsp_tvalid, !rsp_tvalid)

   // Reset leaves the core idle with no result pending.
   `NPCS_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind nearest_palette_color_search_core npcs_checker u_npcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
